/* rtl/core/atlc_pkg.sv */
`default_nettype none
package atlc_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 8;
  // squared distances at or above 2^FAR_LOG2 pixels^2 are off the ramp
  localparam int FAR_LOG2       = 14;
  localparam int LW_BITS        = 8;
  localparam int COV_BITS       = 8;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [COV_BITS-1:0] COV_FULL = 8'd255;
  localparam logic [COV_BITS-1:0] COV_NONE = 8'd0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_END_X      = 3'd2,
    CFG_END_Y      = 3'd3,
    CFG_LINE_WIDTH = 3'd4
  } cfg_idx_t;

  // per-item flags that travel alongside the datapath
  typedef struct packed {
    logic valid;
    logic rect;
    logic full;
    logic far;
  } tag_t;

endpackage
`default_nettype wire

/* rtl/core/atlc_front.sv */
`default_nettype none
module atlc_front import atlc_pkg::*; #(
  parameter int C = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic signed [C-1:0]   pixel_x,
  input  wire logic signed [C-1:0]   pixel_y,
  input  wire logic signed [C-1:0]   start_x,
  input  wire logic signed [C-1:0]   start_y,
  input  wire logic signed [C-1:0]   end_x,
  input  wire logic signed [C-1:0]   end_y,
  input  wire logic [LW_BITS-1:0]    w_eff,
  output tag_t                       tag_o,
  output logic [2*C+15:0]            num_o,
  output logic [2*C:0]               den_o
);

  // segment geometry; the user must hold it static while items are in flight, the block does not enforce it
  logic signed [C:0]     dx, dy;
  logic signed [2*C+1:0] dxx, dyy;
  logic [2*C:0]          len2;
  logic                  horiz, vert;
  logic signed [C-1:0]   lox, hix, loy, hiy;
  logic signed [C+1:0]   half_e, w_e, sx_e, sy_e, x0, x1, y0, y1, pxe, pye;
  logic                  in_h, in_v;

  assign dx    = {end_x[C-1], end_x} - {start_x[C-1], start_x};
  assign dy    = {end_y[C-1], end_y} - {start_y[C-1], start_y};
  assign dxx   = dx * dx;
  assign dyy   = dy * dy;
  assign len2  = {1'b0, dxx[2*C-1:0]} + {1'b0, dyy[2*C-1:0]};
  assign horiz = (start_y == end_y);
  assign vert  = (start_x == end_x);

  assign lox = (start_x < end_x) ? start_x : end_x;
  assign hix = (start_x < end_x) ? end_x : start_x;
  assign loy = (start_y < end_y) ? start_y : end_y;
  assign hiy = (start_y < end_y) ? end_y : start_y;

  assign half_e = $signed({{(C-5){1'b0}}, w_eff[LW_BITS-1:1]});
  assign w_e    = $signed({{(C-6){1'b0}}, w_eff});
  assign sx_e   = {{2{start_x[C-1]}}, start_x};
  assign sy_e   = {{2{start_y[C-1]}}, start_y};
  assign x0     = sx_e - half_e;
  assign x1     = x0 + w_e - (C+2)'(1);
  assign y0     = sy_e - half_e;
  assign y1     = y0 + w_e - (C+2)'(1);
  assign pxe    = {{2{pixel_x[C-1]}}, pixel_x};
  assign pye    = {{2{pixel_y[C-1]}}, pixel_y};

  assign in_h = horiz && (pixel_x >= lox) && (pixel_x <= hix) && (pye >= y0) && (pye <= y1);
  assign in_v = !horiz && vert && (pixel_y >= loy) && (pixel_y <= hiy)
             && (pxe >= x0) && (pxe <= x1);

  // stage a: offsets from both endpoints
  tag_t              tag_a_r, tag_a_nxt;
  logic signed [C:0] px_r, py_r, qx_r, qy_r;

  always_comb begin
    tag_a_nxt.valid = in_valid;
    tag_a_nxt.rect  = horiz || vert;
    tag_a_nxt.full  = in_h || in_v;
    tag_a_nxt.far   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
    end else if (en) begin
      tag_a_r <= tag_a_nxt;
      px_r    <= {pixel_x[C-1], pixel_x} - {start_x[C-1], start_x};
      py_r    <= {pixel_y[C-1], pixel_y} - {start_y[C-1], start_y};
      qx_r    <= {pixel_x[C-1], pixel_x} - {end_x[C-1], end_x};
      qy_r    <= {pixel_y[C-1], pixel_y} - {end_y[C-1], end_y};
    end
  end

  // stage b: dot, cross and endpoint distances
  logic signed [2*C+1:0] pdx, pdy, pxdy, pydx, pxx, pyy, qxx, qyy;
  logic signed [2*C+2:0] dot_r, cross_r;
  logic [2*C:0]          sqs_r, sqe_r;
  tag_t                  tag_b_r;

  assign pdx  = px_r * dx;
  assign pdy  = py_r * dy;
  assign pxdy = px_r * dy;
  assign pydx = py_r * dx;
  assign pxx  = px_r * px_r;
  assign pyy  = py_r * py_r;
  assign qxx  = qx_r * qx_r;
  assign qyy  = qy_r * qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
    end else if (en) begin
      tag_b_r <= tag_a_r;
      dot_r   <= {pdx[2*C+1], pdx} + {pdy[2*C+1], pdy};
      cross_r <= {pxdy[2*C+1], pxdy} - {pydx[2*C+1], pydx};
      sqs_r   <= {1'b0, pxx[2*C-1:0]} + {1'b0, pyy[2*C-1:0]};
      sqe_r   <= {1'b0, qxx[2*C-1:0]} + {1'b0, qyy[2*C-1:0]};
    end
  end

  // stage c: clamp the projection, pick endpoint or perpendicular distance
  logic signed [2*C+2:0] len2_s;
  logic [2*C+2:0]        magf;
  logic                  before_start, past_end, mag_far;
  logic                  is_pt_r;
  logic [2*C:0]          pnum_r;
  logic [C+7:0]          mag_r;
  tag_t                  tag_c_r, tag_c_nxt;

  assign len2_s       = $signed({2'b00, len2});
  assign before_start = dot_r[2*C+2] || (dot_r == '0);
  assign past_end     = (dot_r >= len2_s);
  assign magf         = cross_r[2*C+2] ? -cross_r : cross_r;
  // beyond this the squared distance over len2 is off the ramp for any length
  assign mag_far      = |magf[2*C+2:C+8];

  always_comb begin
    tag_c_nxt     = tag_b_r;
    tag_c_nxt.far = !before_start && !past_end && mag_far;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c_r <= '0;
    end else if (en) begin
      tag_c_r <= tag_c_nxt;
      is_pt_r <= before_start || past_end;
      pnum_r  <= before_start ? sqs_r : sqe_r;
      mag_r   <= magf[C+7:0];
    end
  end

  // stage d: square of the cross magnitude, numerator and denominator
  logic [2*C+15:0] msq;

  assign msq = mag_r * mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_o <= '0;
    end else if (en) begin
      tag_o <= tag_c_r;
      num_o <= is_pt_r ? {15'd0, pnum_r} : msq;
      den_o <= is_pt_r ? (2*C+1)'(1) : len2;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/atlc_div.sv */
`default_nettype none
module atlc_div import atlc_pkg::*; #(
  parameter int NW = 2*COORD_BITS_DEF+16,
  parameter int DW = 2*COORD_BITS_DEF+1,
  parameter int F  = FRAC_BITS_DEF,
  localparam int QB = FAR_LOG2 + 2*F
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  tag_t               tag_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output tag_t               tag_o,
  output logic [QB-1:0]      quo_o
);

  // one quotient bit per stage, stage 0 checks range and loads the remainder
  tag_t                tag_r  [0:QB];
  logic [DW-1:0]       rem_r  [0:QB];
  logic [DW-1:0]       den_r  [0:QB];
  logic [FAR_LOG2-1:0] lb_r   [0:QB];
  logic [QB-1:0]       q_r    [0:QB];

  logic [NW-FAR_LOG2-1:0] hi;
  logic                   far_chk;
  tag_t                   tag0_nxt;

  logic [DW:0]         t      [0:QB-1];
  logic [DW:0]         diff   [0:QB-1];
  logic                ge     [0:QB-1];

  assign hi      = num_i[NW-1:FAR_LOG2];
  assign far_chk = (hi >= (NW-FAR_LOG2)'(den_i));

  always_comb begin
    tag0_nxt     = tag_i;
    tag0_nxt.far = tag_i.far || far_chk;
  end

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      t[j]    = {rem_r[j], lb_r[j][FAR_LOG2-1]};
      diff[j] = t[j] - {1'b0, den_r[j]};
      ge[j]   = (t[j] >= {1'b0, den_r[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) tag_r[j] <= '0;
    end else if (en) begin
      tag_r[0] <= tag0_nxt;
      rem_r[0] <= DW'(hi);
      den_r[0] <= den_i;
      lb_r[0]  <= num_i[FAR_LOG2-1:0];
      q_r[0]   <= '0;
      for (int j = 0; j < QB; j++) begin
        tag_r[j+1] <= tag_r[j];
        rem_r[j+1] <= ge[j] ? diff[j][DW-1:0] : t[j][DW-1:0];
        den_r[j+1] <= den_r[j];
        lb_r[j+1]  <= lb_r[j] << 1;
        q_r[j+1]   <= {q_r[j][QB-2:0], ge[j]};
      end
    end
  end

  assign tag_o = tag_r[QB];
  assign quo_o = q_r[QB];

endmodule
`default_nettype wire

/* rtl/core/atlc_sqrt.sv */
`default_nettype none
module atlc_sqrt import atlc_pkg::*; #(
  parameter int QB = FAR_LOG2 + 2*FRAC_BITS_DEF,
  localparam int RB = QB/2,
  localparam int RW = RB + 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  tag_t               tag_i,
  input  wire logic [QB-1:0] rad_i,
  output tag_t               tag_o,
  output logic [RB-1:0]      root_o
);

  // digit-by-digit integer root, two radicand bits per stage
  tag_t          tag_r  [1:RB];
  logic [RW-1:0] rem_r  [1:RB];
  logic [RB-1:0] root_r [1:RB];
  logic [QB-1:0] rad_r  [1:RB];

  logic [RW-1:0] rem_s  [0:RB-1];
  logic [RB-1:0] root_s [0:RB-1];
  logic [QB-1:0] rad_s  [0:RB-1];
  logic [RW-1:0] remx   [0:RB-1];
  logic [RW-1:0] trial  [0:RB-1];
  logic          ge     [0:RB-1];

  always_comb begin
    for (int j = 0; j < RB; j++) begin
      if (j == 0) begin
        rem_s[j]  = '0;
        root_s[j] = '0;
        rad_s[j]  = rad_i;
      end else begin
        rem_s[j]  = rem_r[j];
        root_s[j] = root_r[j];
        rad_s[j]  = rad_r[j];
      end
      remx[j]  = {rem_s[j][RW-3:0], rad_s[j][QB-1:QB-2]};
      trial[j] = RW'({root_s[j], 2'b01});
      ge[j]    = (remx[j] >= trial[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= RB; j++) tag_r[j] <= '0;
    end else if (en) begin
      tag_r[1] <= tag_i;
      for (int j = 2; j <= RB; j++) tag_r[j] <= tag_r[j-1];
      for (int j = 0; j < RB; j++) begin
        rem_r[j+1]  <= ge[j] ? (remx[j] - trial[j]) : remx[j];
        root_r[j+1] <= {root_s[j][RB-2:0], ge[j]};
        rad_r[j+1]  <= rad_s[j] << 2;
      end
    end
  end

  assign tag_o  = tag_r[RB];
  assign root_o = root_r[RB];

endmodule
`default_nettype wire

/* rtl/core/aa_thick_line_coverage.sv */
// channel   ports                                          direction
// in        in_valid, in_stall, in_pixel_x, in_pixel_y       pixel in
// out       out_valid, out_stall, out_coverage               coverage out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data        register write
//
// one pixel per cycle unless out_stall holds a result; the pipe holds
// four geometry stages, the divider's range-check stage, one bit of the distance
// quotient per stage, one root bit per stage and the output register.
// synchronous active-low reset empties the pipe and loads the register defaults.
// out_stall freezes the whole pipe while out_valid is high; in_stall is raised only while a result is held.
`default_nettype none
module aa_thick_line_coverage import atlc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_pixel_x,
  input  wire logic signed [COORD_BITS-1:0] in_pixel_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [COV_BITS-1:0]               out_coverage
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = 2*C + 16;
  localparam int DW = 2*C + 1;
  localparam int QB = FAR_LOG2 + 2*F;
  localparam int RB = QB/2;

  logic signed [C-1:0]  start_x_r, start_y_r, end_x_r, end_y_r;
  logic [LW_BITS-1:0]   line_width_r, w_eff;
  logic                 en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
      line_width_r <= LW_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_X:    start_x_r    <= cfg_data;
        CFG_START_Y:    start_y_r    <= cfg_data;
        CFG_END_X:      end_x_r      <= cfg_data;
        CFG_END_Y:      end_y_r      <= cfg_data;
        CFG_LINE_WIDTH: line_width_r <= cfg_data[LW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (line_width_r == '0) ? LW_BITS'(1) : line_width_r;

  logic          out_valid_r;
  logic [COV_BITS-1:0] coverage_r, coverage_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  tag_t          tag_f, tag_d, tag_s;
  logic [NW-1:0] num_f;
  logic [DW-1:0] den_f;
  logic [QB-1:0] quo;
  logic [RB-1:0] dist_root;

  atlc_front #(.C(C)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .start_x  (start_x_r),
    .start_y  (start_y_r),
    .end_x    (end_x_r),
    .end_y    (end_y_r),
    .w_eff    (w_eff),
    .tag_o    (tag_f),
    .num_o    (num_f),
    .den_o    (den_f)
  );

  atlc_div #(.NW(NW), .DW(DW), .F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_f),
    .num_i (num_f),
    .den_i (den_f),
    .tag_o (tag_d),
    .quo_o (quo)
  );

  atlc_sqrt #(.QB(QB)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (tag_d),
    .rad_i  (quo),
    .tag_o  (tag_s),
    .root_o (dist_root)
  );

  // ramp: (width + 1)/2 minus distance, one pixel wide
  logic [8:0]          wp1;
  logic [F+7:0]        base;
  logic signed [F+8:0] cr;
  logic [F-1:0]        cl;
  logic [F+7:0]        prod, rnd;

  assign wp1  = {1'b0, w_eff} + 9'd1;
  assign base = {wp1, {(F-1){1'b0}}};
  assign cr   = $signed({1'b0, base} - {2'b00, dist_root});
  assign cl   = cr[F-1:0];
  assign prod = {cl, 8'd0} - {8'd0, cl};
  assign rnd  = prod + (F+8)'(1 << (F-1));

  always_comb begin
    if (tag_s.rect) begin
      coverage_nxt = tag_s.full ? COV_FULL : COV_NONE;
    end else if (tag_s.far || cr[F+8] || (cr == '0)) begin
      coverage_nxt = COV_NONE;
    end else if (|cr[F+7:F]) begin
      coverage_nxt = COV_FULL;
    end else begin
      coverage_nxt = rnd[F+7:F];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_s.valid;
      coverage_r  <= coverage_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_coverage = coverage_r;

endmodule
`default_nettype wire
